FILE: rtl/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types, codes and constants of the servo slew-rate ramp unit.
// ----------------------------------------------------------------------------
package ssr_pkg;

	localparam int PWM_PERIOD_US_DEF   = 20000;
	localparam int ANGLE_FRAC_BITS_DEF = 8;

	localparam int MS_PER_S       = 1000;
	localparam int SERVO_SPAN_DEG = 180;
	localparam int PWM_CNT_BITS   = 12;

	// operation codes on the input stream
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_RAMP = 2'd1;
	localparam logic [OP_W-1:0] OP_PARK = 2'd2;

	// configuration register indexes
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;
	localparam logic [REG_IDX_W-1:0] REG_SLEW_DPS       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_STEP_MS        = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_PULSE_US   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_PULSE_US   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_OUTPUT_CHANNEL = 3'd4;

	localparam logic [9:0]  SLEW_DPS_RST       = 10'd180;
	localparam logic [7:0]  STEP_MS_RST        = 8'd20;
	localparam logic [14:0] MIN_PULSE_US_RST   = 15'd500;
	localparam logic [14:0] MAX_PULSE_US_RST   = 15'd2500;
	localparam logic [3:0]  OUTPUT_CHANNEL_RST = 4'd0;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_RAMP,
		KIND_PARK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  target_deg;
		logic [31:0] now_ms;
	} cmd_t;

	typedef struct packed {
		logic [9:0]  slew_dps;
		logic [7:0]  step_ms;
		logic [14:0] min_pulse_us;
		logic [14:0] max_pulse_us;
		logic [3:0]  output_channel;
	} cfg_t;

endpackage

FILE: rtl/ssr_front.sv
// ----------------------------------------------------------------------------
// ssr_front
// Input stage: accepts stream transactions, decodes the operation into a
// command kind, drops unused codes and registers the command for the queue.
// ----------------------------------------------------------------------------
module ssr_front
	import ssr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,   // target_deg[7:0], now_ms[39:8]
	input  logic [OP_W-1:0]      s_tuser,   // operation[1:0]
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output cmd_t                 cmd
);

	logic      valid_s1;
	cmd_t      cmd_s1;
	logic      known;
	logic      take;
	cmd_kind_t kind;

	always_comb begin
		known = 1'b1;
		kind  = KIND_TICK;
		case (s_tuser)
			OP_TICK: kind = KIND_TICK;
			OP_RAMP: kind = KIND_RAMP;
			OP_PARK: kind = KIND_PARK;
			default: known = 1'b0;
		endcase
	end

	assign s_tready = !valid_s1 || cmd_ready;
	assign take     = s_tvalid && s_tready && known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.kind       <= kind;
			cmd_s1.target_deg <= s_tdata[7:0];
			cmd_s1.now_ms     <= s_tdata[39:8];
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

endmodule

FILE: rtl/ssr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ssr_cmd_fifo
// Two-entry command queue between the input stage and the sequencer.
// ----------------------------------------------------------------------------
module ssr_cmd_fifo
	import ssr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	localparam int DEPTH = 2;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/ssr_back.sv
// ----------------------------------------------------------------------------
// ssr_back
// Sequencer: holds the angle state, computes the ramp step and the pulse
// width in a chain of states, and presents results in an output register.
// ----------------------------------------------------------------------------
module ssr_back
	import ssr_pkg::*;
#(
	parameter int PWM_PERIOD_US   = PWM_PERIOD_US_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmd_t                  cmd,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int F       = ANGLE_FRAC_BITS;
	localparam int AW      = 8 + F;
	localparam int D       = SERVO_SPAN_DEG * (2 ** F);
	localparam int PROD_W  = 26;
	localparam int PF_W    = PROD_W + F;
	localparam int GK_W    = AW + 10;
	localparam int QP_W    = 17;
	localparam int N2_W    = 10 + F;
	localparam int STEP_W  = QP_W + F;
	localparam int NUM_W   = AW + 18;
	localparam int NSH_W   = 23;
	localparam int Q_W     = 16;
	localparam int K_1000  = 36;
	localparam int K_180   = 33;
	localparam int K_PER   = 28;
	localparam logic [26:0] M_1000 = 27'((64'd1 << K_1000) / 64'd1000);
	localparam logic [25:0] M_180  = 26'((64'd1 << K_180) / 64'd180);
	localparam logic [63:0] M_PER  = (64'd1 << K_PER) / 64'(PWM_PERIOD_US);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV1,
		ST_FIX1,
		ST_DIV2,
		ST_FIX2,
		ST_MOVE,
		ST_PMUL,
		ST_PSUM,
		ST_PDIV,
		ST_PFIX,
		ST_TDIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic        arrived;
		logic [7:0]  angle_deg;
		logic [11:0] pulse_ticks;
		logic [14:0] pulse_us;
		logic [3:0]  channel;
	} result_t;

	state_t                   state_q;
	logic [AW-1:0]            cur_q;
	logic [AW-1:0]            tgt_q;
	logic [31:0]              last_q;
	logic [15:0]              el_q;
	logic [PROD_W-1:0]        prod_q;
	logic [AW-1:0]            gap_q;
	logic                     up_q;
	logic [GK_W-1:0]          gk_q;
	logic [QP_W-1:0]          mq_q;
	logic                     clamp_q;
	logic [QP_W-1:0]          qp_q;
	logic [9:0]               rp_q;
	logic [F-1:0]             mq2_q;
	logic [F-1:0]             frac_q;
	logic signed [AW+16:0]    pa_q;
	logic [NUM_W-1:0]         mind_q;
	logic [NSH_W-1:0]         nsh_q;
	logic [Q_W-1:0]           q180_q;
	logic [14:0]              us_q;
	logic [Q_W-1:0]           q3_q;
	logic                     m_tvalid_q;
	result_t                  res_q;

	logic [31:0]              el_full;
	logic [15:0]              el_sat;
	logic [AW-1:0]            cmd_angle;
	logic [52:0]              p_div1;
	logic [26:0]              r_fix1;
	logic [N2_W-1:0]          n2;
	logic [N2_W+26:0]         p_div2;
	logic [N2_W-1:0]          r_fix2;
	logic [STEP_W-1:0]        step;
	logic [AW-1:0]            a_clamp;
	logic signed [15:0]       d_pulse;
	logic signed [NUM_W-1:0]  num;
	logic [48:0]              p_div180;
	logic [23:0]              r_fix180;
	logic [26:0]              n3;
	logic [63:0]              p_per;
	logic [31:0]              r_per;
	logic                     sat_per;
	logic [11:0]              ticks;
	logic                     ld_out;

	always_comb begin
		el_full   = cmd.now_ms - last_q;
		el_sat    = (|el_full[31:16]) ? 16'hFFFF : el_full[15:0];
		cmd_angle = {cmd.target_deg, {F{1'b0}}};

		p_div1 = 53'(prod_q) * 53'(M_1000);
		r_fix1 = 27'(prod_q) - 27'(32'(mq_q) * 32'(MS_PER_S));

		n2     = {rp_q, {F{1'b0}}};
		p_div2 = (N2_W + 27)'(n2) * (N2_W + 27)'(M_1000);
		r_fix2 = n2 - N2_W'(32'(mq2_q) * 32'(MS_PER_S));
		step   = {qp_q, frac_q};

		a_clamp = (cur_q > AW'(D)) ? AW'(D) : cur_q;
		d_pulse = $signed({1'b0, cfg.max_pulse_us}) - $signed({1'b0, cfg.min_pulse_us});
		num     = $signed(mind_q) + NUM_W'(pa_q);

		p_div180 = 49'(nsh_q) * 49'(M_180);
		r_fix180 = 24'(nsh_q) - 24'(32'(q180_q) * 32'(SERVO_SPAN_DEG));

		n3      = {us_q, {PWM_CNT_BITS{1'b0}}};
		p_per   = 64'(n3) * M_PER;
		r_per   = 32'(n3) - 32'(q3_q) * 32'(PWM_PERIOD_US);
		sat_per = 17'(us_q) >= 17'(PWM_PERIOD_US);
		if (sat_per) begin
			ticks = '1;
		end else if (r_per >= 32'(PWM_PERIOD_US)) begin
			ticks = 12'(q3_q + Q_W'(1));
		end else begin
			ticks = 12'(q3_q);
		end

		ld_out = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
	end

	assign cmd_ready = state_q == ST_IDLE;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_q      <= '0;
			tgt_q      <= '0;
			last_q     <= '0;
			el_q       <= '0;
			prod_q     <= '0;
			gap_q      <= '0;
			up_q       <= 1'b0;
			gk_q       <= '0;
			mq_q       <= '0;
			clamp_q    <= 1'b0;
			qp_q       <= '0;
			rp_q       <= '0;
			mq2_q      <= '0;
			frac_q     <= '0;
			pa_q       <= '0;
			mind_q     <= '0;
			nsh_q      <= '0;
			q180_q     <= '0;
			us_q       <= '0;
			q3_q       <= '0;
			m_tvalid_q <= 1'b0;
			res_q      <= '0;
		end else begin
			if (ld_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.kind)
							KIND_PARK: begin
								cur_q   <= cmd_angle;
								tgt_q   <= cmd_angle;
								last_q  <= cmd.now_ms;
								state_q <= ST_PMUL;
							end
							KIND_RAMP: begin
								tgt_q  <= cmd_angle;
								last_q <= cmd.now_ms;
							end
							KIND_TICK: begin
								if (cur_q != tgt_q && el_sat >= 16'(cfg.step_ms)) begin
									last_q  <= cmd.now_ms;
									el_q    <= el_sat;
									state_q <= ST_MUL;
								end
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					prod_q  <= PROD_W'(cfg.slew_dps) * PROD_W'(el_q);
					up_q    <= cur_q < tgt_q;
					gap_q   <= (cur_q < tgt_q) ? tgt_q - cur_q : cur_q - tgt_q;
					state_q <= ST_DIV1;
				end
				ST_DIV1: begin
					gk_q    <= GK_W'(gap_q) * GK_W'(MS_PER_S);
					mq_q    <= p_div1[K_1000 +: QP_W];
					state_q <= ST_FIX1;
				end
				ST_FIX1: begin
					clamp_q <= {prod_q, {F{1'b0}}} >= PF_W'(gk_q);
					if (r_fix1 >= 27'(MS_PER_S)) begin
						qp_q <= mq_q + QP_W'(1);
						rp_q <= 10'(r_fix1 - 27'(MS_PER_S));
					end else begin
						qp_q <= mq_q;
						rp_q <= 10'(r_fix1);
					end
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					mq2_q   <= p_div2[K_1000 +: F];
					state_q <= ST_FIX2;
				end
				ST_FIX2: begin
					frac_q  <= (r_fix2 >= N2_W'(MS_PER_S)) ? mq2_q + F'(1) : mq2_q;
					state_q <= ST_MOVE;
				end
				ST_MOVE: begin
					if (clamp_q) begin
						cur_q <= tgt_q;
					end else if (up_q) begin
						cur_q <= cur_q + step[AW-1:0];
					end else begin
						cur_q <= cur_q - step[AW-1:0];
					end
					state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					pa_q    <= (AW+17)'($signed({1'b0, a_clamp})) * (AW+17)'(d_pulse);
					mind_q  <= NUM_W'(cfg.min_pulse_us) * NUM_W'(D);
					state_q <= ST_PSUM;
				end
				ST_PSUM: begin
					nsh_q   <= num[NUM_W-1] ? '0 : num[F +: NSH_W];
					state_q <= ST_PDIV;
				end
				ST_PDIV: begin
					q180_q  <= p_div180[K_180 +: Q_W];
					state_q <= ST_PFIX;
				end
				ST_PFIX: begin
					if (r_fix180 >= 24'(SERVO_SPAN_DEG)) begin
						us_q <= 15'(q180_q + Q_W'(1));
					end else begin
						us_q <= 15'(q180_q);
					end
					state_q <= ST_TDIV;
				end
				ST_TDIV: begin
					q3_q    <= p_per[K_PER +: Q_W];
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (ld_out) begin
						res_q.channel     <= cfg.output_channel;
						res_q.pulse_us    <= us_q;
						res_q.pulse_ticks <= ticks;
						res_q.angle_deg   <= cur_q[AW-1 -: 8];
						res_q.arrived     <= cur_q == tgt_q;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_rem_ms: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV2 |-> rp_q < 10'(MS_PER_S))
		else $error("step remainder out of range");

	a_step_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE && !clamp_q) |-> step < STEP_W'(gap_q))
		else $error("unclamped step reaches the target gap");

	a_nsh_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PFIX |-> nsh_q < NSH_W'(SERVO_SPAN_DEG * 32768))
		else $error("pulse numerator out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |-> (!m_tvalid_q || m_tready))
		else $error("result overwritten while pending");

endmodule

FILE: rtl/servo_slew_rate_ramp_unit.sv
// ----------------------------------------------------------------------------
// servo_slew_rate_ramp_unit
// Slew-rate limited servo positioner with pulse-width and PWM count output.
// ----------------------------------------------------------------------------
// path: input stage register, command queue, then the sequencer states PMUL,
// PSUM, PDIV, PFIX, TDIV and EMIT (a stepping tick first passes MUL, DIV1, FIX1,
// DIV2, FIX2 and MOVE) until the result register is loaded; commands: one per
// sequencer pass, and ramps, idle and early ticks leave the sequencer in idle
// reset: arst_n clears angles, timer, queue and handshakes; registers take
// their default values
module servo_slew_rate_ramp_unit
	import ssr_pkg::*;
#(
	parameter int PWM_PERIOD_US   = PWM_PERIOD_US_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // target_deg[7:0], now_ms[39:8]
	input  logic [OP_W-1:0]       s_tuser,   // operation[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // channel[3:0], pulse_us[18:4],
	                                         // pulse_ticks[30:19], angle_deg[38:31],
	                                         // arrived[39]
);

	cfg_t cfg_q;
	logic fr_valid;
	logic fr_ready;
	cmd_t fr_cmd;
	logic bk_valid;
	logic bk_ready;
	cmd_t bk_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slew_dps       <= SLEW_DPS_RST;
			cfg_q.step_ms        <= STEP_MS_RST;
			cfg_q.min_pulse_us   <= MIN_PULSE_US_RST;
			cfg_q.max_pulse_us   <= MAX_PULSE_US_RST;
			cfg_q.output_channel <= OUTPUT_CHANNEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLEW_DPS: begin
					cfg_q.slew_dps <= (cfg_data[9:0] == '0) ? 10'd1 : cfg_data[9:0];
				end
				REG_STEP_MS:        cfg_q.step_ms        <= cfg_data[7:0];
				REG_MIN_PULSE_US:   cfg_q.min_pulse_us   <= cfg_data[14:0];
				REG_MAX_PULSE_US:   cfg_q.max_pulse_us   <= cfg_data[14:0];
				REG_OUTPUT_CHANNEL: cfg_q.output_channel <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	ssr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd       (fr_cmd)
	);

	ssr_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_cmd),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_data   (bk_cmd)
	);

	ssr_back #(
		.PWM_PERIOD_US   (PWM_PERIOD_US),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (bk_valid),
		.cmd_ready (bk_ready),
		.cmd       (bk_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives park, ramp and tick commands into the servo slew-rate ramp unit under
// several register settings and compares every pulse transaction, field by
// field, with a cycle-free predictor of the angle ramp and pulse-width math.
// ----------------------------------------------------------------------------
module testbench;
	import ssr_pkg::*;

	localparam int FRAC         = ANGLE_FRAC_BITS_DEF;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 500;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic        arrived;
		logic [7:0]  angle_deg;
		logic [11:0] pulse_ticks;
		logic [14:0] pulse_us;
		logic [3:0]  channel;
	} pulse_rec_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // target_deg, now_ms
	logic [OP_W-1:0]       s_tuser = '0;   // operation
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // channel, pulse_us, pulse_ticks,
	                                       // angle_deg, arrived

	// predictor copy of the registers and the servo state
	logic [9:0]  slew_rate    = SLEW_DPS_RST;
	logic [7:0]  step_min_ms  = STEP_MS_RST;
	logic [14:0] pulse_min_us = MIN_PULSE_US_RST;
	logic [14:0] pulse_max_us = MAX_PULSE_US_RST;
	logic [3:0]  pwm_channel  = OUTPUT_CHANNEL_RST;
	logic [15:0] servo_angle  = '0;
	logic [15:0] servo_target = '0;
	logic [31:0] last_step_ms = '0;

	pulse_rec_t pulse_expected[$];
	pulse_rec_t pulse_want;
	pulse_rec_t pulse_got;
	int         errors = 0;
	int         cycle_count = 0;
	bit         no_stall = 1'b0;

	servo_slew_rate_ramp_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= no_stall || ($urandom_range(0, 99) >= 15);
	end

	function automatic pulse_rec_t pulse_for_angle();
		longint den, a, d, num, us, ticks;
		pulse_rec_t r;
		den = longint'(SERVO_SPAN_DEG) << FRAC;
		a = longint'(servo_angle);
		if (a > den)
			a = den;
		d = longint'(pulse_max_us) - longint'(pulse_min_us);
		num = longint'(pulse_min_us) * den + a * d;
		if (num < 0)
			num = 0;
		us = num / den;
		ticks = us * (1 << PWM_CNT_BITS) / PWM_PERIOD_US_DEF;
		if (ticks > (1 << PWM_CNT_BITS) - 1)
			ticks = (1 << PWM_CNT_BITS) - 1;
		r.channel = pwm_channel;
		r.pulse_us = us[14:0];
		r.pulse_ticks = ticks[11:0];
		r.angle_deg = servo_angle[15:FRAC];
		r.arrived = (servo_angle == servo_target);
		return r;
	endfunction

	// advances the servo state by one command, returns 1 when a pulse results
	function automatic bit servo_step(input logic [OP_W-1:0] op, input logic [7:0] deg,
			input logic [31:0] now, output pulse_rec_t r);
		logic [15:0] angle;
		logic [31:0] elapsed;
		longint unsigned step, gap;
		angle = 16'(deg) << FRAC;
		r = '0;
		case (op)
			OP_PARK: begin
				servo_angle = angle;
				servo_target = angle;
				last_step_ms = now;
				r = pulse_for_angle();
				return 1'b1;
			end
			OP_RAMP: begin
				servo_target = angle;
				last_step_ms = now;
				return 1'b0;
			end
			OP_TICK: begin
				if (servo_angle == servo_target)
					return 1'b0;
				elapsed = now - last_step_ms;
				if (elapsed > 32'd65535)
					elapsed = 32'd65535;
				if (elapsed < 32'(step_min_ms))
					return 1'b0;
				last_step_ms = now;
				step = ((64'(slew_rate) * 64'(elapsed)) << FRAC) / MS_PER_S;
				if (servo_angle < servo_target) begin
					gap = servo_target - servo_angle;
					servo_angle = (step >= gap) ? servo_target : servo_angle + 16'(step);
				end else begin
					gap = servo_angle - servo_target;
					servo_angle = (step >= gap) ? servo_target : servo_angle - 16'(step);
				end
				r = pulse_for_angle();
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic check_field(input string name, input int unsigned want_v, got_v);
		if (want_v != got_v) begin
			$error("%s expected %0d got %0d", name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			pulse_got = m_tdata;
			if (pulse_expected.size() == 0) begin
				$error("unexpected pulse transaction %h", m_tdata);
				errors++;
			end else begin
				pulse_want = pulse_expected.pop_front();
				check_field("channel", pulse_want.channel, pulse_got.channel);
				check_field("pulse_us", pulse_want.pulse_us, pulse_got.pulse_us);
				check_field("pulse_ticks", pulse_want.pulse_ticks, pulse_got.pulse_ticks);
				check_field("angle_deg", pulse_want.angle_deg, pulse_got.angle_deg);
				check_field("arrived", pulse_want.arrived, pulse_got.arrived);
			end
		end
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic [7:0] deg,
			input logic [31:0] now);
		pulse_rec_t r;
		if (!no_stall && $urandom_range(0, 99) < 15) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {now, deg};
		do @(posedge clk); while (!s_tready);
		if (servo_step(op, deg, now, r))
			pulse_expected.push_back(r);
	endtask

	// wait for every pulse, then for the tail of a command that gives none
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pulse_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_SLEW_DPS:       slew_rate = (val[9:0] == '0) ? 10'd1 : val[9:0];
			REG_STEP_MS:        step_min_ms = val[7:0];
			REG_MIN_PULSE_US:   pulse_min_us = val;
			REG_MAX_PULSE_US:   pulse_max_us = val;
			REG_OUTPUT_CHANNEL: pwm_channel = val[3:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] random_deg();
		return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(181, 255))
			: 8'($urandom_range(0, 180));
	endfunction

	task automatic test_park_extremes();
		send_item(OP_PARK, 8'd0, 32'd0);
		send_item(OP_PARK, 8'd180, 32'hFFFF_FFFF);
		send_item(OP_PARK, 8'd255, 32'h5555_5555);
		send_item(OP_PARK, 8'hAA, 32'hAAAA_AAAA);
		send_item(OP_PARK, 8'h55, 32'd0);
	endtask

	task automatic test_ramp_steps();
		send_item(OP_PARK, 8'd0, 32'd1000);
		send_item(OP_RAMP, 8'd180, 32'd1000);
		send_item(OP_TICK, 8'd0, 32'd1010);     // too early
		send_item(OP_TICK, 8'd0, 32'd1020);     // one full step
		send_item(OP_TICK, 8'd0, 32'd1020);     // no time passed
		send_item(OP_TICK, 8'd0, 32'd900000);   // saturated elapsed, arrives
		send_item(OP_TICK, 8'd0, 32'd900100);   // idle
		send_item(OP_RAMP, 8'd0, 32'd2000);
		send_item(OP_TICK, 8'd0, 32'd1999);     // timestamp wrapped
		send_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_register_corners();
		drain();
		write_reg(REG_SLEW_DPS, '0);
		write_reg(REG_STEP_MS, 15'd1);
		send_item(OP_PARK, 8'd10, 32'd0);
		send_item(OP_RAMP, 8'd11, 32'd0);
		send_item(OP_TICK, 8'd0, 32'd1);    // zero-size step
		send_item(OP_TICK, 8'd0, 32'd3);
		drain();
		write_reg(REG_MIN_PULSE_US, 15'd2500);
		write_reg(REG_MAX_PULSE_US, 15'd500);
		send_item(OP_PARK, 8'd90, 32'd0);
		drain();
		write_reg(REG_MIN_PULSE_US, 15'd20000);
		write_reg(REG_MAX_PULSE_US, 15'd20000);
		send_item(OP_PARK, 8'd45, 32'd0);
		drain();
		write_reg(REG_MIN_PULSE_US, '0);
		write_reg(REG_MAX_PULSE_US, '1);
		write_reg(REG_OUTPUT_CHANNEL, 15'd15);
		for (int i = REG_OUTPUT_CHANNEL + 1; i < (1 << REG_IDX_W); i++)
			write_reg(i[REG_IDX_W-1:0], '1);
		send_item(OP_PARK, 8'd200, 32'd5);
		send_item(OP_PARK, 8'd180, 32'd5);
		drain();
		write_reg(REG_SLEW_DPS, '1);
		send_item(OP_PARK, 8'd0, 32'd7);
	endtask

	task automatic test_random_traffic();
		int kind, sent;
		logic [31:0] clock_ms;
		logic [14:0] slew_v, step_v, min_v, max_v, chan_v;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					slew_v = 15'(SLEW_DPS_RST);
					step_v = 15'(STEP_MS_RST);
					min_v = MIN_PULSE_US_RST;
					max_v = MAX_PULSE_US_RST;
					chan_v = 15'(OUTPUT_CHANNEL_RST);
				end
				1: begin
					slew_v = 15'd1023;
					step_v = 15'd1;
					min_v = 15'd0;
					max_v = 15'd20000;
					chan_v = 15'd9;
				end
				2: begin
					slew_v = 15'd1;
					step_v = 15'd255;
					min_v = 15'd2500;
					max_v = 15'd500;
					chan_v = 15'd6;
				end
				default: begin
					slew_v = 15'($urandom_range(0, 1023));
					step_v = 15'($urandom_range(0, 255));
					min_v = 15'($urandom_range(0, 20000));
					max_v = 15'($urandom_range(0, 20000));
					chan_v = 15'($urandom_range(0, 15));
				end
			endcase
			drain();
			write_reg(REG_SLEW_DPS, slew_v);
			write_reg(REG_STEP_MS, step_v);
			write_reg(REG_MIN_PULSE_US, min_v);
			write_reg(REG_MAX_PULSE_US, max_v);
			write_reg(REG_OUTPUT_CHANNEL, chan_v);
			no_stall = (phase == 2);
			clock_ms = $urandom;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				kind = $urandom_range(0, 99);
				if (kind < 8) begin
					send_item(OP_PARK, random_deg(), clock_ms);
				end else if (kind < 20) begin
					send_item(OP_RAMP, random_deg(), clock_ms);
				end else if (kind < 88) begin
					clock_ms += $urandom_range(0, 2 * step_min_ms + 2);
					send_item(OP_TICK, 8'($urandom), clock_ms);
				end else if (kind < 93) begin
					send_item(OP_TICK, 8'($urandom), $urandom);
				end else if (kind < 96) begin
					send_item(OP_UNUSED, 8'($urandom), $urandom);
					continue;
				end else begin
					clock_ms -= $urandom_range(1, 50);
					send_item(OP_TICK, 8'($urandom), clock_ms);
				end
				sent++;
			end
		end
		no_stall = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_park_extremes();
		test_ramp_steps();
		test_register_corners();
		test_random_traffic();
		drain();
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
